// ===== rtl/rsi_pkg.sv =====
// Shared constants and types for the ray/sphere intersection core.
`default_nettype none
package rsi_pkg;
  localparam int COORD_W    = 32;
  localparam int DIST_W     = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_reg_t;

  // square-root pipeline: 72-bit radicand, one root bit per stage
  localparam int SQRT_IN_W  = 72;
  localparam int SQRT_OUT_W = 36;

  // normal divider: one quotient bit per stage
  localparam int DIV_NUM_W = 62;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_Q_W   = 31;

  // epsilon 1e-4 in Q16.16 is 6.55 LSB: a root counts when above this
  localparam int EPS_LSB = 6;
  localparam logic signed [COORD_W-1:0] DIR_ONE = 32'sh4000_0000;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
endpackage
`default_nettype wire

// ===== rtl/rsi_if.sv =====
// Ray input and hit result channel interfaces.
`default_nettype none
interface rsi_in_if;
  logic valid;
  logic ready;
  logic signed [rsi_pkg::COORD_W-1:0] origin_x;
  logic signed [rsi_pkg::COORD_W-1:0] origin_y;
  logic signed [rsi_pkg::COORD_W-1:0] origin_z;
  logic signed [rsi_pkg::COORD_W-1:0] dir_x;
  logic signed [rsi_pkg::COORD_W-1:0] dir_y;
  logic signed [rsi_pkg::COORD_W-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rsi_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic [rsi_pkg::DIST_W-1:0] distance;
  logic signed [rsi_pkg::COORD_W-1:0] normal_x;
  logic signed [rsi_pkg::COORD_W-1:0] normal_y;
  logic signed [rsi_pkg::COORD_W-1:0] normal_z;
  logic inside_res;

  modport source (output valid, hit, distance, normal_x, normal_y, normal_z, inside_res,
                  input ready);
  modport sink (input valid, hit, distance, normal_x, normal_y, normal_z, inside_res,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/ray_sphere_intersect_core.sv =====
// Ray/sphere intersection core: one ray per cycle against a configured sphere.
// Each accepted ray passes 120 register stages, the last being the output
// register; a new ray can be taken every cycle while the result side keeps up,
// and the whole pipeline holds when the output register is full and not taken.
// Depth is set by two 36-stage square-root pipelines (discriminant root and
// normal length) and a 31-stage divider per normal component. Positions,
// radius and distance are Q16.16, directions and normals Q2.30; distance
// saturates at its maximum.
// A miss returns all fields zero; a hit point on the centre gives a zero normal.
// Write the sphere registers only while no ray is in flight.
`default_nettype none
module ray_sphere_intersect_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  rsi_in_if.sink                                in_ch,
  rsi_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [rsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rsi_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int SQ = rsi_pkg::SQRT_OUT_W;
  localparam int DV = rsi_pkg::DIV_Q_W;

  typedef struct packed {
    logic [2:0][32:0] v;
    logic [2:0][31:0] d;
  } vd_t;

  typedef struct packed {
    logic             miss;
    logic [35:0]      b;
    vd_t              vd;
  } sb1_t;

  typedef struct packed {
    logic             hit;
    logic [30:0]      dst;
    logic [2:0]       neg;
    logic [2:0][30:0] as;
    logic [2:0][31:0] d;
  } sb2_t;

  typedef struct packed {
    logic             hit;
    logic             lenz;
    logic [30:0]      dst;
    logic [2:0]       neg;
    logic [2:0][31:0] d;
  } sb3_t;

  function automatic logic signed [31:0] clamp_dir(input logic signed [31:0] x);
    if (x > rsi_pkg::DIR_ONE) return rsi_pkg::DIR_ONE;
    if (x < -rsi_pkg::DIR_ONE) return -rsi_pkg::DIR_ONE;
    return x;
  endfunction

  logic en;
  logic in_fire;

  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0]        rad_r;

  // valid bits
  logic [5:0]    pre_vld_r;
  logic [SQ-1:0] sb1_vld_r;
  logic [6:0]    mid_vld_r;
  logic [SQ-1:0] sb2_vld_r;
  logic          s14_vld_r;
  logic [DV-1:0] sb3_vld_r;
  logic          s15_vld_r, s16_vld_r, out_vld_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_fire     = in_ch.valid && en;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= '0;
    end else if (cfg_we) begin
      case (rsi_pkg::cfg_reg_t'(cfg_index))
        rsi_pkg::CFG_CENTER_X: cx_r  <= cfg_data;
        rsi_pkg::CFG_CENTER_Y: cy_r  <= cfg_data;
        rsi_pkg::CFG_CENTER_Z: cz_r  <= cfg_data;
        rsi_pkg::CFG_RADIUS:   rad_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= '0;
      sb1_vld_r <= '0;
      mid_vld_r <= '0;
      sb2_vld_r <= '0;
      s14_vld_r <= 1'b0;
      sb3_vld_r <= '0;
      s15_vld_r <= 1'b0;
      s16_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      pre_vld_r <= {pre_vld_r[4:0], in_fire};
      sb1_vld_r <= {sb1_vld_r[SQ-2:0], pre_vld_r[5]};
      mid_vld_r <= {mid_vld_r[5:0], sb1_vld_r[SQ-1]};
      sb2_vld_r <= {sb2_vld_r[SQ-2:0], mid_vld_r[6]};
      s14_vld_r <= sb2_vld_r[SQ-1];
      sb3_vld_r <= {sb3_vld_r[DV-2:0], s14_vld_r};
      s15_vld_r <= sb3_vld_r[DV-1];
      s16_vld_r <= s15_vld_r;
      out_vld_r <= s16_vld_r;
    end
  end

  // s1: v = center - origin, clamp direction
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] ctr [3];
  vd_t s1_vd_r;

  always_comb begin
    org[0] = in_ch.origin_x;
    org[1] = in_ch.origin_y;
    org[2] = in_ch.origin_z;
    dir[0] = in_ch.dir_x;
    dir[1] = in_ch.dir_y;
    dir[2] = in_ch.dir_z;
    ctr[0] = cx_r;
    ctr[1] = cy_r;
    ctr[2] = cz_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_vd_r.v[i] <= 33'(ctr[i]) - 33'(org[i]);
        s1_vd_r.d[i] <= clamp_dir(dir[i]);
      end
    end
  end

  // s2: v.d products, |v|^2 terms, r^2
  logic [32:0]        vm [3];
  logic signed [64:0] s2_p_r [3];
  logic [64:0]        s2_vsq_r [3];
  logic [61:0]        s2_r2_r;
  vd_t                s2_vd_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vm[i] = s1_vd_r.v[i][32] ? 33'(-$signed(s1_vd_r.v[i])) : s1_vd_r.v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_p_r[i]   <= $signed(s1_vd_r.v[i]) * $signed(s1_vd_r.d[i]);
        // magnitude 2^32 is the only case with the top bit set
        s2_vsq_r[i] <= vm[i][32] ? (65'(1) << 64) : 65'(vm[i][31:0]) * 65'(vm[i][31:0]);
      end
      s2_r2_r <= 62'(rad_r) * 62'(rad_r);
      s2_vd_r <= s1_vd_r;
    end
  end

  // s3: b = floor(v.d / 2^30), |v|^2
  logic signed [65:0] psum;
  logic signed [35:0] s3_b_r;
  logic [66:0]        s3_vv_r;
  logic [61:0]        s3_r2_r;
  vd_t                s3_vd_r;

  assign psum = 66'(s2_p_r[0]) + 66'(s2_p_r[1]) + 66'(s2_p_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_b_r  <= psum[65:30];
      s3_vv_r <= 67'(s2_vsq_r[0]) + 67'(s2_vsq_r[1]) + 67'(s2_vsq_r[2]);
      s3_r2_r <= s2_r2_r;
      s3_vd_r <= s2_vd_r;
    end
  end

  // s4: b^2 as partial products (|b| < 2^34)
  logic [34:0] bm;
  logic [63:0] s4_ll_r;
  logic [34:0] s4_hl_r;
  logic [5:0]  s4_hh_r;
  logic [66:0] s4_vv_r;
  logic [61:0] s4_r2_r;
  logic [35:0] s4_b_r;
  vd_t         s4_vd_r;

  assign bm = s3_b_r[35] ? 35'(-s3_b_r) : 35'(s3_b_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ll_r <= 64'(bm[31:0]) * 64'(bm[31:0]);
      s4_hl_r <= 35'(bm[34:32]) * 35'(bm[31:0]);
      s4_hh_r <= 6'(bm[34:32]) * 6'(bm[34:32]);
      s4_vv_r <= s3_vv_r;
      s4_r2_r <= s3_r2_r;
      s4_b_r  <= s3_b_r;
      s4_vd_r <= s3_vd_r;
    end
  end

  // s5: b^2 + r^2
  logic [70:0] s5_lhs_r;
  logic [66:0] s5_vv_r;
  logic [35:0] s5_b_r;
  vd_t         s5_vd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_lhs_r <= 71'(s4_ll_r) + (71'(s4_hl_r) << 33) + (71'(s4_hh_r) << 64) + 71'(s4_r2_r);
      s5_vv_r  <= s4_vv_r;
      s5_b_r   <= s4_b_r;
      s5_vd_r  <= s4_vd_r;
    end
  end

  // s6: discriminant
  logic [71:0] diff;
  logic [71:0] s6_det_r;
  sb1_t        s6_sb_r;

  assign diff = {1'b0, s5_lhs_r} - 72'(s5_vv_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s6_det_r      <= diff[71] ? '0 : diff;
      s6_sb_r.miss  <= diff[71];
      s6_sb_r.b     <= s5_b_r;
      s6_sb_r.vd    <= s5_vd_r;
    end
  end

  logic [SQ-1:0] root1;
  sb1_t          sb1_r [SQ];

  rsi_sqrt_pipe u_sqrt_det (
    .clk  (clk),
    .en   (en),
    .x    (s6_det_r),
    .root (root1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r[0] <= s6_sb_r;
      for (int k = 1; k < SQ; k++) sb1_r[k] <= sb1_r[k-1];
    end
  end

  // s7: choose root
  logic signed [35:0] bq;
  logic signed [37:0] bms, bps;
  logic               near_ok, far_ok;
  logic [36:0]        s7_t_r;
  logic               s7_hit_r;
  vd_t                s7_vd_r;

  always_comb begin
    bq      = $signed(sb1_r[SQ-1].b);
    bms     = 38'(bq) - $signed({2'b00, root1});
    bps     = 38'(bq) + $signed({2'b00, root1});
    near_ok = bms > 38'(rsi_pkg::EPS_LSB);
    far_ok  = bps > 38'(rsi_pkg::EPS_LSB);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_t_r   <= near_ok ? bms[36:0] : bps[36:0];
      s7_hit_r <= !sb1_r[SQ-1].miss && (near_ok || far_ok);
      s7_vd_r  <= sb1_r[SQ-1].vd;
    end
  end

  // s8: dir * t in two parts, saturate distance
  logic signed [62:0] s8_pl_r [3];
  logic signed [39:0] s8_ph_r [3];
  logic [30:0]        s8_dist_r;
  logic               s8_hit_r;
  vd_t                s8_vd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s8_pl_r[i] <= $signed(s7_vd_r.d[i]) * $signed({1'b0, s7_t_r[29:0]});
        s8_ph_r[i] <= $signed(s7_vd_r.d[i]) * $signed({1'b0, s7_t_r[36:30]});
      end
      if (!s7_hit_r) s8_dist_r <= '0;
      else if (s7_t_r > 37'(rsi_pkg::DIST_MAX)) s8_dist_r <= rsi_pkg::DIST_MAX;
      else s8_dist_r <= s7_t_r[30:0];
      s8_hit_r <= s7_hit_r;
      s8_vd_r  <= s7_vd_r;
    end
  end

  // s9: hit point relative to the centre
  logic signed [40:0] s9_w_r [3];
  logic [30:0]        s9_dist_r;
  logic               s9_hit_r;
  logic [2:0][31:0]   s9_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s9_w_r[i] <= 41'(s8_ph_r[i]) + 41'($signed(s8_pl_r[i][62:30]))
                     - 41'($signed(s8_vd_r.v[i]));
      end
      s9_dist_r <= s8_dist_r;
      s9_hit_r  <= s8_hit_r;
      s9_d_r    <= s8_vd_r.d;
    end
  end

  // s10: magnitudes
  logic [39:0]      s10_a_r [3];
  logic [2:0]       s10_neg_r;
  logic [30:0]      s10_dist_r;
  logic             s10_hit_r;
  logic [2:0][31:0] s10_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s10_a_r[i]   <= s9_w_r[i][40] ? 40'(-s9_w_r[i]) : 40'(s9_w_r[i]);
        s10_neg_r[i] <= s9_w_r[i][40];
      end
      s10_dist_r <= s9_dist_r;
      s10_hit_r  <= s9_hit_r;
      s10_d_r    <= s9_d_r;
    end
  end

  // s11: scale down until every component fits in 31 bits
  logic [39:0]      aor;
  logic [3:0]       shk;
  logic [2:0][30:0] s11_as_r;
  logic [2:0]       s11_neg_r;
  logic [30:0]      s11_dist_r;
  logic             s11_hit_r;
  logic [2:0][31:0] s11_d_r;

  always_comb begin
    aor = s10_a_r[0] | s10_a_r[1] | s10_a_r[2];
    shk = '0;
    for (int j = 31; j < 40; j++) begin
      if (aor[j]) shk = 4'(j - 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s11_as_r[i] <= 31'(s10_a_r[i] >> shk);
      s11_neg_r  <= s10_neg_r;
      s11_dist_r <= s10_dist_r;
      s11_hit_r  <= s10_hit_r;
      s11_d_r    <= s10_d_r;
    end
  end

  // s12: squares
  logic [61:0] s12_sq_r [3];
  sb2_t        s12_sb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s12_sq_r[i] <= 62'(s11_as_r[i]) * 62'(s11_as_r[i]);
      s12_sb_r.hit <= s11_hit_r;
      s12_sb_r.dst <= s11_dist_r;
      s12_sb_r.neg <= s11_neg_r;
      s12_sb_r.as  <= s11_as_r;
      s12_sb_r.d   <= s11_d_r;
    end
  end

  // s13: sum of squares
  logic [63:0] s13_sq_r;
  sb2_t        s13_sb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s13_sq_r <= 64'(s12_sq_r[0]) + 64'(s12_sq_r[1]) + 64'(s12_sq_r[2]);
      s13_sb_r <= s12_sb_r;
    end
  end

  logic [SQ-1:0] root2;
  sb2_t          sb2_r [SQ];

  rsi_sqrt_pipe u_sqrt_len (
    .clk  (clk),
    .en   (en),
    .x    (rsi_pkg::SQRT_IN_W'(s13_sq_r)),
    .root (root2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_r[0] <= s13_sb_r;
      for (int k = 1; k < SQ; k++) sb2_r[k] <= sb2_r[k-1];
    end
  end

  // s14: numerators with half-len rounding
  logic [31:0] len;
  logic [61:0] s14_num_r [3];
  logic [31:0] s14_len_r;
  sb3_t        s14_sb_r;

  assign len = root2[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s14_num_r[i] <= {1'b0, sb2_r[SQ-1].as[i], 30'b0} + 62'(len[31:1]);
      end
      s14_len_r     <= len;
      s14_sb_r.hit  <= sb2_r[SQ-1].hit;
      s14_sb_r.lenz <= (len == '0);
      s14_sb_r.dst  <= sb2_r[SQ-1].dst;
      s14_sb_r.neg  <= sb2_r[SQ-1].neg;
      s14_sb_r.d    <= sb2_r[SQ-1].d;
    end
  end

  logic [DV-1:0] quo [3];
  sb3_t          sb3_r [DV];

  for (genvar i = 0; i < 3; i++) begin : g_div
    rsi_div_pipe u_div (
      .clk (clk),
      .en  (en),
      .num (s14_num_r[i]),
      .den (s14_len_r),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb3_r[0] <= s14_sb_r;
      for (int k = 1; k < DV; k++) sb3_r[k] <= sb3_r[k-1];
    end
  end

  // s15: signed normal, zero on miss or degenerate length
  logic signed [31:0] s15_n_r [3];
  logic [30:0]        s15_dist_r;
  logic               s15_hit_r;
  logic [2:0][31:0]   s15_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (!sb3_r[DV-1].hit || sb3_r[DV-1].lenz) s15_n_r[i] <= '0;
        else if (sb3_r[DV-1].neg[i]) s15_n_r[i] <= -$signed({1'b0, quo[i]});
        else s15_n_r[i] <= $signed({1'b0, quo[i]});
      end
      s15_dist_r <= sb3_r[DV-1].dst;
      s15_hit_r  <= sb3_r[DV-1].hit;
      s15_d_r    <= sb3_r[DV-1].d;
    end
  end

  // s16: dir . normal products
  logic signed [63:0] s16_dp_r [3];
  logic signed [31:0] s16_n_r [3];
  logic [30:0]        s16_dist_r;
  logic               s16_hit_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s16_dp_r[i] <= $signed(s15_d_r[i]) * s15_n_r[i];
        s16_n_r[i]  <= s15_n_r[i];
      end
      s16_dist_r <= s15_dist_r;
      s16_hit_r  <= s15_hit_r;
    end
  end

  // output register
  logic signed [65:0] dot;
  logic               out_hit_r, out_inside_r;
  logic [30:0]        out_dist_r;
  logic signed [31:0] out_n_r [3];

  assign dot = 66'(s16_dp_r[0]) + 66'(s16_dp_r[1]) + 66'(s16_dp_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r    <= s16_hit_r;
      out_dist_r   <= s16_dist_r;
      out_inside_r <= dot > 66'sd0;
      for (int i = 0; i < 3; i++) out_n_r[i] <= s16_n_r[i];
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.distance   = out_dist_r;
  assign out_ch.normal_x   = out_n_r[0];
  assign out_ch.normal_y   = out_n_r[1];
  assign out_ch.normal_z   = out_n_r[2];
  assign out_ch.inside_res = out_inside_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.hit |-> out_ch.distance == '0 && out_ch.normal_x == '0 &&
      out_ch.normal_y == '0 && out_ch.normal_z == '0 && !out_ch.inside_res)
    else $error("miss result carries nonzero fields");

  a_hit_beyond_eps: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit |-> out_ch.distance > 31'(rsi_pkg::EPS_LSB))
    else $error("hit distance not beyond epsilon");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.normal_x <= rsi_pkg::DIR_ONE &&
      out_ch.normal_x >= -rsi_pkg::DIR_ONE && out_ch.normal_y <= rsi_pkg::DIR_ONE &&
      out_ch.normal_y >= -rsi_pkg::DIR_ONE && out_ch.normal_z <= rsi_pkg::DIR_ONE &&
      out_ch.normal_z >= -rsi_pkg::DIR_ONE)
    else $error("normal component beyond unit range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s6_det_r) && $stable(s13_sq_r) && $stable(mid_vld_r))
    else $error("pipeline advanced during stall");
endmodule
`default_nettype wire

// ===== rtl/rsi_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit resolved per stage.
`default_nettype none
module rsi_sqrt_pipe (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [rsi_pkg::SQRT_IN_W-1:0]   x,
  output logic      [rsi_pkg::SQRT_OUT_W-1:0]  root
);
  localparam int NS = rsi_pkg::SQRT_OUT_W;
  localparam int XW = rsi_pkg::SQRT_IN_W;

  logic [XW-1:0] rem_r  [NS];
  logic [NS-1:0] root_r [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam int B = NS - 1 - i;
    logic [XW-1:0] rem_in;
    logic [NS-1:0] root_in;
    logic [XW:0]   trial;

    if (i == 0) begin : g_first
      assign rem_in  = x;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    // (root + 2^B)^2 - root^2, with root bits below B+1 still zero
    assign trial = ((XW+1)'(root_in) << (B + 1)) + ((XW+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_r[i]  <= rem_in - trial[XW-1:0];
          root_r[i] <= root_in | (NS'(1) << B);
        end else begin
          rem_r[i]  <= rem_in;
          root_r[i] <= root_in;
        end
      end
    end
  end

  assign root = root_r[NS-1];
endmodule
`default_nettype wire

// ===== rtl/rsi_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rsi_div_pipe (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [rsi_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [rsi_pkg::DIV_DEN_W-1:0]  den,
  output logic      [rsi_pkg::DIV_Q_W-1:0]    quo
);
  localparam int NS = rsi_pkg::DIV_Q_W;
  localparam int NW = rsi_pkg::DIV_NUM_W;
  localparam int DW = rsi_pkg::DIV_DEN_W;

  logic [NW-1:0] rem_r [NS];
  logic [DW-1:0] den_r [NS];
  logic [NS-1:0] q_r   [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam int J = NS - 1 - i;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [NS-1:0] q_in;
    logic [NW:0]   trial;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign trial = (NW+1)'(den_in) << J;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i] <= den_in;
        if ({1'b0, rem_in} >= trial) begin
          rem_r[i] <= rem_in - trial[NW-1:0];
          q_r[i]   <= q_in | (NS'(1) << J);
        end else begin
          rem_r[i] <= rem_in;
          q_r[i]   <= q_in;
        end
      end
    end
  end

  assign quo = q_r[NS-1];
endmodule
`default_nettype wire

// ===== tb/ray_sphere_intersect_core_tb.sv =====
// Self-checking testbench for the ray/sphere intersection core.
`timescale 1ns / 1ps
module ray_sphere_intersect_core_tb;

  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        distance;
    logic signed [31:0] nx, ny, nz;
    logic               inside_flag;
  } hit_t;

  localparam int IDLE_LIMIT = 4000;
  localparam logic signed [31:0] ONE = 32'sh4000_0000;
  localparam logic signed [31:0] UNIT = 32'sh0001_0000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rsi_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rsi_pkg::CFG_DATA_W-1:0] cfg_data;

  rsi_in_if in_ch ();
  rsi_out_if out_ch ();

  ray_sphere_intersect_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow copy of the sphere registers
  logic signed [31:0] sph_cx, sph_cy, sph_cz;
  logic [30:0] sph_r;

  ray_t ray_queue[$];
  hit_t hit_expect[$];
  int errors = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [127:0] isqrt128(logic signed [127:0] x, int top);
    logic signed [127:0] res, cand;
    res = 0;
    for (int bt = top; bt >= 0; bt--) begin
      cand = res | (128'sd1 <<< bt);
      if (cand * cand <= x) res = cand;
    end
    return res;
  endfunction

  function automatic hit_t predict_hit(ray_t r);
    logic signed [127:0] v[3], d[3], w[3], a[3];
    logic signed [127:0] b, rr, lhs, vv, det, s, t, mx, sq, len, m, dot;
    hit_t res;
    int k;
    res = '0;
    v[0] = sph_cx; v[1] = sph_cy; v[2] = sph_cz;
    v[0] = v[0] - r.ox; v[1] = v[1] - r.oy; v[2] = v[2] - r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    for (int i = 0; i < 3; i++) begin
      if (d[i] > ONE) d[i] = ONE;
      if (d[i] < -ONE) d[i] = -ONE;
    end
    b = (v[0] * d[0] + v[1] * d[1] + v[2] * d[2]) >>> 30;
    rr = {97'd0, sph_r};
    lhs = b * b + rr * rr;
    vv = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    if (lhs < vv) return res;
    det = lhs - vv;
    s = isqrt128(det, 63);
    if (b - s > rsi_pkg::EPS_LSB) t = b - s;
    else if (b + s > rsi_pkg::EPS_LSB) t = b + s;
    else return res;
    res.hit = 1'b1;
    res.distance = (t > 128'sh7FFF_FFFF) ? rsi_pkg::DIST_MAX : t[30:0];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      w[i] = ((d[i] * t) >>> 30) - v[i];
      a[i] = (w[i] < 0) ? -w[i] : w[i];
      if (a[i] > mx) mx = a[i];
    end
    k = 0;
    while ((mx >>> k) >= 128'sh8000_0000) k++;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = a[i] >>> k;
      sq += a[i] * a[i];
    end
    len = isqrt128(sq, 31);
    if (len == 0) return res;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      m = ((a[i] <<< 30) + (len >>> 1)) / len;
      if (w[i] < 0) m = -m;
      dot += d[i] * m;
      if (i == 0) res.nx = m[31:0];
      else if (i == 1) res.ny = m[31:0];
      else res.nz = m[31:0];
    end
    res.inside_flag = (dot > 0);
    return res;
  endfunction

  // ---------------- ray driver: bursts with random gaps ----------------
  int burst_left, gap_left;
  ray_t ray_cur;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.origin_x <= '0;
      in_ch.origin_y <= '0;
      in_ch.origin_z <= '0;
      in_ch.dir_x <= '0;
      in_ch.dir_y <= '0;
      in_ch.dir_z <= '0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) hit_expect.push_back(predict_hit(ray_cur));
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered ray until transfer
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (ray_queue.size() > 0) begin
        ray_cur = ray_queue.pop_front();
        in_ch.origin_x <= ray_cur.ox;
        in_ch.origin_y <= ray_cur.oy;
        in_ch.origin_z <= ray_cur.oz;
        in_ch.dir_x <= ray_cur.dx;
        in_ch.dir_y <= ray_cur.dy;
        in_ch.dir_z <= ray_cur.dz;
        in_ch.valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------- result monitor and receiver stalls ----------------
  int out_count = 0;
  int long_left = 0;
  bit long_done = 0;
  int stall_mode = 0;
  int mode_cnt = 0;
  hit_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_count++;
        if (hit_expect.size() == 0) begin
          $display("%0t: unexpected result transfer, got hit %b dist %h", $time,
                   out_ch.hit, out_ch.distance);
          errors++;
        end else begin
          want = hit_expect.pop_front();
          if (out_ch.hit !== want.hit) begin
            $display("%0t: hit mismatch exp %b got %b", $time, want.hit, out_ch.hit);
            errors++;
          end
          if (out_ch.distance !== want.distance) begin
            $display("%0t: distance mismatch exp %h got %h", $time, want.distance,
                     out_ch.distance);
            errors++;
          end
          if (out_ch.normal_x !== want.nx) begin
            $display("%0t: normal_x mismatch exp %h got %h", $time, want.nx, out_ch.normal_x);
            errors++;
          end
          if (out_ch.normal_y !== want.ny) begin
            $display("%0t: normal_y mismatch exp %h got %h", $time, want.ny, out_ch.normal_y);
            errors++;
          end
          if (out_ch.normal_z !== want.nz) begin
            $display("%0t: normal_z mismatch exp %h got %h", $time, want.nz, out_ch.normal_z);
            errors++;
          end
          if (out_ch.inside_res !== want.inside_flag) begin
            $display("%0t: inside_res mismatch exp %b got %b", $time, want.inside_flag,
                     out_ch.inside_res);
            errors++;
          end
        end
      end
      if (long_left > 0) begin
        long_left--;
        out_ch.ready <= 1'b0;
      end else if (!long_done && out_count >= 150) begin
        // hold off long enough to fill the pipeline and back up the input
        long_done = 1;
        long_left = 400;
        out_ch.ready <= 1'b0;
      end else begin
        mode_cnt++;
        if (mode_cnt % 64 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------- watchdog ----------------
  int idle_cnt = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (ray_queue.size() == 0 && hit_expect.size() == 0 && !in_ch.valid))
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("ray_sphere_intersect_core_tb: errors");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic write_reg(rsi_pkg::cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      rsi_pkg::CFG_CENTER_X: sph_cx = val;
      rsi_pkg::CFG_CENTER_Y: sph_cy = val;
      rsi_pkg::CFG_CENTER_Z: sph_cz = val;
      default: sph_r = val[30:0];
    endcase
  endtask

  task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] r);
    write_reg(rsi_pkg::CFG_CENTER_X, cx);
    write_reg(rsi_pkg::CFG_CENTER_Y, cy);
    write_reg(rsi_pkg::CFG_CENTER_Z, cz);
    write_reg(rsi_pkg::CFG_RADIUS, r);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    ray_t r;
    r = {ox, oy, oz, dx, dy, dz};
    ray_queue.push_back(r);
  endtask

  task automatic drain();
    while (ray_queue.size() != 0 || hit_expect.size() != 0 || in_ch.valid) @(posedge clk);
  endtask

  // aim a ray from near the sphere toward a point around it, or send noise
  task automatic push_random_ray();
    real c[3], o[3], tg[3], dv[3], rad, span, mag;
    logic signed [31:0] oi[3], di[3];
    if ($urandom_range(0, 4) == 0) begin
      push_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      return;
    end
    c[0] = $itor(sph_cx); c[1] = $itor(sph_cy); c[2] = $itor(sph_cz);
    rad = $itor(sph_r);
    span = rad * 3.0 + 65536.0 * $urandom_range(1, 64);
    for (int i = 0; i < 3; i++) begin
      o[i] = c[i] + span * ($itor($urandom_range(0, 2000)) / 1000.0 - 1.0);
      if (o[i] > 2147483647.0) o[i] = 2147483647.0;
      if (o[i] < -2147483648.0) o[i] = -2147483648.0;
      tg[i] = c[i] + rad * 1.3 * ($itor($urandom_range(0, 2000)) / 1000.0 - 1.0);
      oi[i] = $rtoi(o[i]);
      dv[i] = tg[i] - $itor(oi[i]);
    end
    mag = $sqrt(dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2]);
    if (mag < 1.0) begin
      di[0] = 0; di[1] = 0; di[2] = ONE;
    end else begin
      for (int i = 0; i < 3; i++) di[i] = $rtoi(dv[i] / mag * 1073741824.0);
    end
    // flip now and then to shoot away from the sphere
    if ($urandom_range(0, 9) == 0) for (int i = 0; i < 3; i++) di[i] = -di[i];
    push_ray(oi[0], oi[1], oi[2], di[0], di[1], di[2]);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= rsi_pkg::CFG_CENTER_X;
    cfg_data <= '0;
    sph_cx = 0; sph_cy = 0; sph_cz = 0; sph_r = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sphere: zero radius at the origin
    push_ray(0, 0, -32'sd10 * UNIT, 0, 0, ONE);   // hit lands on the centre
    push_ray(0, 0, 0, 0, 0, ONE);                  // zero discriminant, no root
    push_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, ONE);
    drain();

    set_sphere(0, 0, 0, UNIT);
    push_ray(0, 0, -32'sd5 * UNIT, 0, 0, ONE);     // near root
    push_ray(0, 0, 0, ONE, 0, 0);                  // inside: far root
    push_ray(0, 0, -32'sd5 * UNIT, 0, 0, -ONE);    // pointing away
    push_ray(UNIT, 0, -32'sd5 * UNIT, 0, 0, ONE);  // tangent
    push_ray(0, 32'sd2 * UNIT, -32'sd5 * UNIT, 0, 0, ONE); // clear miss
    push_ray(0, 0, -32'sd5 * UNIT, 0, 0, 32'sh7FFF_FFFF);  // saturated direction
    push_ray(0, -32'sd5 * UNIT, 0, 0, 32'sh8000_0000, 0);
    push_ray(0, 0, -32'sd5 * UNIT, 32'sh2D41_3CCD, 0, 32'sh2D41_3CCD);
    push_ray(0, 0, UNIT, 0, 0, ONE);               // on the surface, leaving
    push_ray(0, 0, -UNIT - 3, 0, 0, ONE);          // root just under epsilon
    push_ray(0, 0, -UNIT - 7, 0, 0, ONE);          // root just over epsilon
    push_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -ONE, -ONE, -ONE);
    drain();

    // extreme corners, saturating distance
    set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh24F3_4E8B, 32'sh24F3_4E8B, 32'sh24F3_4E8B);
    push_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, ONE, 0, 0);
    push_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, ONE, ONE, ONE);
    drain();
    set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    push_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -ONE, -ONE, -ONE);
    push_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, ONE, 0);
    push_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, -ONE, 0, 0);
    drain();

    // random spheres, rays mostly aimed at them
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5)
        set_sphere($urandom, $urandom, $urandom, $urandom);
      else
        set_sphere($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000,
                   $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000,
                   $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000,
                   $urandom_range(1, 32'h0040_0000));
      for (int n = 0; n < 170; n++) push_random_ray();
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("ray_sphere_intersect_core_tb: clean");
    else
      $display("ray_sphere_intersect_core_tb: errors");
    $finish;
  end
endmodule
